### src/fireq_pkg.sv
// Shared constants, types and sequencer states for the FIR equalizer with volume.
// Used by fireq_mac, fir_equalizer_with_volume_top and tb; depends on nothing else.
package fireq_pkg;

  // Filter length and derived index widths.
  localparam int TAPS  = 64;
  localparam int TAP_W = $clog2(TAPS);
  localparam int CNT_W = $clog2(TAPS + 1);

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int INDEX_W  = 6;
  localparam int GAIN_W   = 16;
  localparam int ACC_W    = 32;

  // Shared multiplier operands are one bit wider so the unsigned gain fits.
  localparam int OP_W   = 17;
  localparam int PROD_W = 2 * OP_W;

  // Shift applied after the gain multiply (Q8.8 gain).
  localparam int GAIN_FRAC = 8;
  localparam int SCALED_W  = PROD_W - GAIN_FRAC;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

  // Word kinds carried on tuser.
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_MULG,
    ST_SAT
  } state_t;

  // Controls from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic acc_clear;
    logic acc_add;
    logic sel_gain;
  } dp_ctrl_t;

endpackage

### src/fireq_mac.sv
// Shared multiply-accumulate unit: one registered multiplier used for every tap
// and then for the volume gain, the 32-bit accumulator and the output clamp.
// Depends on fireq_pkg.
module fireq_mac
  import fireq_pkg::*;
(
  input  logic                       clk,
  input  dp_ctrl_t                   ctrl,
  input  logic signed [SAMPLE_W-1:0] dl_op,
  input  logic signed [COEF_W-1:0]   cf_op,
  input  logic        [GAIN_W-1:0]   gain,
  output logic signed [SAMPLE_W-1:0] result
);

  logic signed [OP_W-1:0]     op_a;
  logic signed [OP_W-1:0]     op_b;
  logic signed [PROD_W-1:0]   prod_q;
  logic        [ACC_W-1:0]    acc;
  logic signed [SCALED_W-1:0] scaled;

  // Operand select: tap pair, or the accumulator's upper half times the gain.
  always_comb begin
    if (ctrl.sel_gain) begin
      op_a = {acc[ACC_W-1], acc[ACC_W-1:ACC_W-SAMPLE_W]};
      op_b = {1'b0, gain};
    end else begin
      op_a = {dl_op[SAMPLE_W-1], dl_op};
      op_b = {cf_op[COEF_W-1], cf_op};
    end
  end

  // The one multiplier, registered.
  always_ff @(posedge clk) begin
    prod_q <= op_a * op_b;
  end

  // Wrapping accumulator over the tap products.
  always_ff @(posedge clk) begin
    if (ctrl.acc_clear) begin
      acc <= '0;
    end else if (ctrl.acc_add) begin
      acc <= acc + prod_q[ACC_W-1:0];
    end
  end

  // Floor shift of the gain product, then clamp to the 16-bit range.
  assign scaled = prod_q[PROD_W-1:GAIN_FRAC];

  always_comb begin
    if (scaled > SCALED_W'(32767)) begin
      result = 16'sh7FFF;
    end else if (scaled < -SCALED_W'(32768)) begin
      result = 16'sh8000;
    end else begin
      result = scaled[SAMPLE_W-1:0];
    end
  end

endmodule

### src/fir_equalizer_with_volume_top.sv
// Top level of the FIR equalizer with volume: stream ports, sequencer, delay
// line and coefficient memories. Depends on fireq_pkg and fireq_mac.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  tdata: sample, tap_index, coefficient; tuser: kind
//   m_*       out  m_tvalid/m_tready  tdata: filtered
//   cfg_*     in   cfg_wr_en          cfg_wr_data: volume gain (Q8.8)
//
// A filter word runs from acceptance through one memory read and one multiply per
// tap, a drain of the read and multiply pipeline, one gain multiply and one clamp
// step before the next word can be accepted. A load word is taken in the idle state,
// which the sequencer does not leave for it.
// Reset clears the delay line and coefficients through per-entry valid bits and
// sets the gain to unity. A result still waiting on m_tready holds the clamp
// step, and no new word is taken until the output register is free.
module fir_equalizer_with_volume_top
  import fireq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,     // sample[15:0], tap_index[21:16], coefficient[37:22]
  input  logic              s_tuser,     // kind: 0 filter a sample, 1 load a coefficient
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,     // filtered[15:0]
  input  logic              cfg_wr_en,
  input  logic [GAIN_W-1:0] cfg_wr_data
);

  state_t                     state;
  state_t                     state_next;
  logic [CNT_W-1:0]           cnt;
  logic [TAP_W-1:0]           rptr;
  logic [TAP_W-1:0]           wptr;
  logic signed [SAMPLE_W-1:0] smp_q;
  logic [GAIN_W-1:0]          gain;

  logic signed [SAMPLE_W-1:0] delay_mem [TAPS];
  logic signed [COEF_W-1:0]   coef_mem  [TAPS];
  logic [TAPS-1:0]            dl_valid;
  logic [TAPS-1:0]            cf_valid;
  logic signed [SAMPLE_W-1:0] dl_rd;
  logic signed [COEF_W-1:0]   cf_rd;
  logic                       dl_ok;
  logic                       cf_ok;
  logic signed [SAMPLE_W-1:0] dl_op;
  logic signed [COEF_W-1:0]   cf_op;
  logic                       v1;
  logic                       v2;

  logic                       accept;
  logic                       is_load;
  logic                       load_we;
  logic [TAP_W-1:0]           load_idx;
  logic [TAP_W-1:0]           cidx;
  logic                       issue;
  logic                       out_free;
  logic                       commit;
  dp_ctrl_t                   ctrl;
  logic signed [SAMPLE_W-1:0] result;

  logic signed [SAMPLE_W-1:0] in_sample;
  logic [INDEX_W-1:0]         in_index;
  logic signed [COEF_W-1:0]   in_coef;

  // Unpack the input word.
  assign in_sample = s_tdata[15:0];
  assign in_index  = s_tdata[21:16];
  assign in_coef   = s_tdata[37:22];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_load  = (s_tuser == ACT_LOAD);
  assign load_idx = TAP_W'(in_index);
  assign load_we  = accept && is_load && (int'(in_index) < TAPS);
  assign cidx     = cnt[TAP_W-1:0];
  assign out_free = !m_tvalid || m_tready;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !is_load) state_next = ST_MAC;
      end
      ST_MAC: begin
        if (cnt == CNT_W'(TAPS - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1 && !v2) state_next = ST_MULG;
      end
      ST_MULG: begin
        state_next = ST_SAT;
      end
      ST_SAT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs. The gain operands stay selected through the clamp step
  // so the gain product holds while the result waits for the output register.
  always_comb begin
    issue         = 1'b0;
    commit        = 1'b0;
    ctrl.acc_clear = accept && !is_load;
    ctrl.acc_add   = v2;
    ctrl.sel_gain  = 1'b0;
    case (state)
      ST_MAC:  issue         = 1'b1;
      ST_MULG: ctrl.sel_gain = 1'b1;
      ST_SAT: begin
        ctrl.sel_gain = 1'b1;
        commit        = out_free;
      end
      default: begin
      end
    endcase
  end

  // Tap counter, read pointer and read pipeline flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      rptr <= '0;
      wptr <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (accept) begin
        cnt  <= '0;
        rptr <= wptr;
      end else if (issue) begin
        cnt  <= cnt + CNT_W'(1);
        rptr <= (rptr == TAP_W'(TAPS - 1)) ? '0 : rptr + TAP_W'(1);
      end
      if (commit) begin
        wptr <= (wptr == TAP_W'(TAPS - 1)) ? '0 : wptr + TAP_W'(1);
      end
    end
  end

  // Current sample waits here until its taps are summed.
  always_ff @(posedge clk) begin
    if (accept && !is_load) smp_q <= in_sample;
  end

  // Volume register.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain <= cfg_wr_data;
    end
  end

  // Delay line: circular buffer, wptr marks the oldest entry.
  always_ff @(posedge clk) begin
    if (commit) delay_mem[wptr] <= smp_q;
    if (issue)  dl_rd <= delay_mem[rptr];
  end

  // Coefficient memory.
  always_ff @(posedge clk) begin
    if (load_we) coef_mem[load_idx] <= in_coef;
    if (issue)   cf_rd <= coef_mem[cidx];
  end

  // Entry valid bits stand in for the reset clearing of both stores.
  always_ff @(posedge clk) begin
    if (rst) begin
      dl_valid <= '0;
      cf_valid <= '0;
      dl_ok    <= 1'b0;
      cf_ok    <= 1'b0;
    end else begin
      if (commit)  dl_valid[wptr]     <= 1'b1;
      if (load_we) cf_valid[load_idx] <= 1'b1;
      if (issue) begin
        dl_ok <= dl_valid[rptr];
        cf_ok <= cf_valid[cidx];
      end
    end
  end

  assign dl_op = dl_ok ? dl_rd : '0;
  assign cf_op = cf_ok ? cf_rd : '0;

  fireq_mac u_mac (
    .clk    (clk),
    .ctrl   (ctrl),
    .dl_op  (dl_op),
    .cf_op  (cf_op),
    .gain   (gain),
    .result (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) m_tdata <= result;
  end

`ifndef NO_ASSERTIONS
  // A product reaches the accumulator only in the cycle after its read came back.
  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("tap product without a preceding read");

  // The gain multiply must not overlap tap products still in flight.
  a_gain_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULG) |-> (!v1 && !v2))
    else $error("gain multiply started before the taps drained");

  // A new result appears only from the clamp step.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_SAT))
    else $error("result shown outside the clamp step");

  // Every filter word reads exactly TAPS entries.
  a_tap_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) && ($past(state) == ST_MAC) |-> (cnt == CNT_W'(TAPS)))
    else $error("wrong number of taps read");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fir_equalizer_with_volume_top: drives sample and
// coefficient-load words and gain settings, predicts every filtered output and compares it.
// Depends on fireq_pkg and the RTL of the filter; reads no files.
module tb;
  import fireq_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 3;
  localparam int TOTAL_WORDS   = 1450;
  localparam int SETTLE_CYCLES = TAPS + 12;
  localparam int CYCLE_LIMIT   = 1_000_000;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [39:0]       s_tdata;     // sample[15:0], tap_index[21:16], coefficient[37:22]
  logic              s_tuser;     // kind: filter a sample or load a coefficient
  logic              m_tvalid;
  logic              m_tready;
  logic [15:0]       m_tdata;     // filtered[15:0]
  logic              cfg_wr_en;
  logic [GAIN_W-1:0] cfg_wr_data;

  // Predictor state: sample history (index 0 oldest), coefficients and gain.
  logic signed [SAMPLE_W-1:0] sample_history [TAPS];
  logic signed [COEF_W-1:0]   coef_bank [TAPS];
  logic [GAIN_W-1:0]          gain_setting;
  logic [15:0]                expected_filtered [$];

  int err_count;
  int words_sent;
  int cycle_count;
  bit no_idle;

  fir_equalizer_with_volume_top DUT (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Free-running clock, 20 ns period.
  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Filter output for the current history: wrapping 32-bit sum, floor shifts,
  // gain multiply and clamp to the signed 16-bit range.
  function automatic logic [15:0] compute_filtered();
    logic signed [ACC_W-1:0] acc;
    longint scaled;
    int k;
    acc = '0;
    for (k = 0; k < TAPS; k++) begin
      acc = acc + sample_history[k] * coef_bank[k];
    end
    scaled = longint'(acc) >>> 16;
    scaled = (scaled * longint'(gain_setting)) >>> GAIN_FRAC;
    if (scaled > 32767) begin
      scaled = 32767;
    end else if (scaled < -32768) begin
      scaled = -32768;
    end
    return scaled[15:0];
  endfunction

  // Random 16-bit value with the extremes weighted up.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Small coefficient so that the sum rarely wraps or clamps.
  function automatic logic [15:0] small_coef();
    logic signed [15:0] c;
    c = 16'($urandom_range(0, 4095));
    c = c - 16'sd2048;
    return c;
  endfunction

  // Sends one word and updates the predictor once it is accepted.
  task automatic send_word(logic kind, logic [15:0] smp, logic [5:0] idx, logic [15:0] coef);
    int k;
    if (!no_idle && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      if ($urandom_range(0, 19) == 0) begin
        // An occasional long gap shifts arrivals across the whole MAC pass.
        repeat ($urandom_range(1, TAPS + 8)) @(posedge clk);
      end else begin
        do @(posedge clk); while ($urandom_range(0, 99) < 20);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, coef, idx, smp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    if (kind == ACT_LOAD) begin
      if (int'(idx) < TAPS) begin
        coef_bank[idx] = coef;
      end
    end else begin
      expected_filtered.push_back(compute_filtered());
      for (k = 0; k < TAPS - 1; k++) begin
        sample_history[k] = sample_history[k + 1];
      end
      sample_history[TAPS - 1] = smp;
    end
  endtask

  task automatic send_sample(logic [15:0] smp);
    send_word(ACT_FILTER, smp, 6'($urandom), 16'($urandom));
  endtask

  task automatic send_load(logic [5:0] idx, logic [15:0] coef);
    send_word(ACT_LOAD, 16'($urandom), idx, coef);
  endtask

  // Waits until every output has come back and the block has gone quiet.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_filtered.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_gain(logic [GAIN_W-1:0] gain);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= gain;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    gain_setting = gain;
  endtask

  // Mixed loads and samples with random content.
  task automatic run_mixed(int count);
    int i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 25) begin
        send_load(6'($urandom), pick_value());
      end else begin
        send_sample(pick_value());
      end
    end
  endtask

  // Rewrites every coefficient, either small values or the full range.
  task automatic load_profile(bit gentle);
    int k;
    for (k = 0; k < TAPS; k++) begin
      send_load(6'(k), gentle ? small_coef() : pick_value());
    end
  endtask

  // Coefficients and history start cleared; the floor shift rounds -0.5 down.
  task automatic test_cleared_state();
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_load(6'd0, 16'h7FFF);
    send_load(6'd63, 16'h8000);
    send_sample(16'h0000);
  endtask

  // Two full-scale products wrap the accumulator to its most negative value.
  task automatic test_accumulator_wrap();
    send_load(6'd62, 16'h8000);
    send_load(6'd63, 16'h8000);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h0000);
  endtask

  // Unity gain stays in range; full gain clamps both ways; zero gain mutes.
  task automatic test_gain_extremes();
    send_load(6'd62, 16'h0000);
    send_load(6'd63, 16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    set_gain(16'hFFFF);
    send_sample(16'h7FFF);
    send_load(6'd63, 16'h8000);
    send_sample(16'h0000);
    set_gain(16'h0000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    set_gain(16'h0001);
    send_sample(16'h0000);
  endtask

  // A few gain settings, each with a short random run.
  task automatic test_gain_settings();
    set_gain(GAIN_RESET);
    run_mixed(30);
    set_gain(16'h0080);
    run_mixed(30);
    set_gain(16'h0300);
    run_mixed(30);
    set_gain(16'($urandom));
    run_mixed(30);
  endtask

  // Both sides without idle cycles for a long stretch.
  task automatic test_back_to_back();
    set_gain(GAIN_RESET);
    no_idle = 1'b1;
    load_profile(1'b1);
    run_mixed(150);
    no_idle = 1'b0;
  endtask

  // Random coefficient profiles and runs, with gain changes now and then.
  task automatic test_random_traffic();
    int next_gain_change;
    next_gain_change = words_sent + 250;
    while (words_sent < TOTAL_WORDS) begin
      if (words_sent >= next_gain_change) begin
        case ($urandom_range(0, 3))
          0:       set_gain(16'hFFFF);
          1:       set_gain(GAIN_RESET);
          default: set_gain(16'($urandom_range(0, 1023)));
        endcase
        next_gain_change = words_sent + 250;
      end
      if ($urandom_range(0, 3) == 0) begin
        load_profile($urandom_range(0, 2) != 0);
      end else begin
        run_mixed($urandom_range(20, 60));
      end
    end
  endtask

  // Receiver stalls about a fifth of the time, except in the no-idle stretch.
  always @(posedge clk) begin
    m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 20);
  end

  // Compares each accepted output word with the oldest prediction.
  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_filtered.size() == 0) begin
        $error("filtered: no output expected, got %0d", $signed(m_tdata));
        err_count++;
      end else begin
        want = expected_filtered.pop_front();
        if (m_tdata !== want) begin
          $error("filtered: expected %0d, got %0d", $signed(want), $signed(m_tdata));
          err_count++;
        end
      end
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    err_count    = 0;
    words_sent   = 0;
    cycle_count  = 0;
    no_idle      = 1'b0;
    gain_setting = GAIN_RESET;
    for (int k = 0; k < TAPS; k++) begin
      sample_history[k] = '0;
      coef_bank[k]      = '0;
    end
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= ACT_FILTER;
    m_tready    <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_cleared_state();
    test_accumulator_wrap();
    test_gain_extremes();
    test_gain_settings();
    test_back_to_back();
    test_random_traffic();

    wait_idle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
